// ===== rtl/rat_pkg.sv =====
// Package for the range alias translation table: word types, controller
// command and status structs, state enum and shared constants.
// No dependencies.
`default_nettype none

package rat_pkg;

  // Default table depth
  localparam int unsigned TableEntriesDef = 16;

  // Width of the entries_in_use register
  localparam int unsigned CfgW = 5;

  // Request type codes
  localparam logic ReqLookup = 1'b0;
  localparam logic ReqWrite  = 1'b1;

  // Input word
  typedef struct packed {
    logic        req_type;
    logic [3:0]  entry_index;
    logic        entry_live;
    logic [63:0] entry_base;
    logic [63:0] entry_length;
    logic [63:0] entry_alias;
    logic [63:0] lookup_address;
    logic [63:0] access_size;
  } req_t;

  // Result word
  typedef struct packed {
    logic        hit;
    logic [63:0] alias_address;
  } rsp_t;

  // One stored table entry (live bit kept apart in flops)
  typedef struct packed {
    logic [63:0] alias_base;
    logic [63:0] length;
    logic [63:0] base;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResult
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_en;      // store the input word's entry
    logic lk_load;    // capture lookup address and size
    logic rd_en;      // read one entry into the compare pipe
    logic flush;      // drop everything in the compare pipe
    logic res_clear;  // result := miss
    logic res_hit;    // result := hit with the pipe's sum
    logic out_load;   // move result into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic match;  // last pipe stage holds a containing live entry
    logic busy;   // some pipe stage still holds an entry
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rat_datapath.sv =====
// Datapath of the range alias table: entry RAM, live bits, three-stage
// containment compare, result and output registers.
// Depends on rat_pkg and rat_ram.
`default_nettype none

module rat_datapath #(
  parameter int unsigned TableEntries = rat_pkg::TableEntriesDef,
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rat_pkg::req_t       in_word_i,
  input  wire rat_pkg::ctrl_cmd_t  cmd_i,
  input  wire logic [IdxW-1:0]     rd_addr_i,
  output rat_pkg::dp_status_t      status_o,
  output rat_pkg::rsp_t            out_word_o
);

  import rat_pkg::*;

  // Write address and range check
  logic [31:0]     wr_idx;
  logic [IdxW-1:0] wr_addr;
  logic            wr_in_range;
  logic            ram_we;
  entry_t          wr_entry;
  entry_t          rd_entry;

  assign wr_idx      = 32'(in_word_i.entry_index);
  assign wr_addr     = wr_idx[IdxW-1:0];
  assign wr_in_range = wr_idx < TableEntries;
  assign ram_we      = cmd_i.wr_en && wr_in_range;

  assign wr_entry.alias_base = in_word_i.entry_alias;
  assign wr_entry.length     = in_word_i.entry_length;
  assign wr_entry.base       = in_word_i.entry_base;

  rat_ram #(
    .Width ($bits(entry_t)),
    .Depth (TableEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_entry)
  );

  // Live bits, cleared at reset
  logic live_q [TableEntries];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) begin
        live_q[i] <= 1'b0;
      end
    end else if (ram_we) begin
      live_q[wr_addr] <= in_word_i.entry_live;
    end
  end

  // Lookup operands
  logic [63:0] lk_addr_q;
  logic [63:0] lk_size_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_load) begin
      lk_addr_q <= in_word_i.lookup_address;
      lk_size_q <= in_word_i.access_size;
    end
  end

  // Pipe valids: stage 1 = RAM output, stage 2 = differences, stage 3 = decision
  logic v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (cmd_i.flush) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: live bit read alongside the RAM
  logic live1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      live1_q <= live_q[rd_addr_i];
    end
  end

  // Stage 1 -> 2: offset into entry and room left for the access
  logic        ge1, szok1;
  logic [63:0] off1, room1;

  assign ge1   = lk_addr_q >= rd_entry.base;
  assign off1  = lk_addr_q - rd_entry.base;
  assign szok1 = lk_size_q <= rd_entry.length;
  assign room1 = rd_entry.length - lk_size_q;

  logic        live2_q, ge2_q, szok2_q;
  logic [63:0] off2_q, room2_q, alias2_q;

  always_ff @(posedge clk_i) begin
    live2_q  <= live1_q;
    ge2_q    <= ge1;
    szok2_q  <= szok1;
    off2_q   <= off1;
    room2_q  <= room1;
    alias2_q <= rd_entry.alias_base;
  end

  // Stage 2 -> 3: containment decision and translated address
  logic        match2;
  logic [63:0] sum2;

  assign match2 = live2_q && ge2_q && szok2_q && (off2_q <= room2_q);
  assign sum2   = alias2_q + off2_q;

  logic        match3_q;
  logic [63:0] sum3_q;

  always_ff @(posedge clk_i) begin
    match3_q <= match2;
    sum3_q   <= sum2;
  end

  assign status_o.match = v3_q && match3_q;
  assign status_o.busy  = v1_q || v2_q || v3_q;

  // Result register
  rsp_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_clear) begin
      res_q <= '0;
    end else if (cmd_i.res_hit) begin
      res_q.hit           <= 1'b1;
      res_q.alias_address <= sum3_q;
    end
  end

  // Output register
  rsp_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/rat_ctrl.sv =====
// Controller of the range alias table: handshakes, entries_in_use
// register, scan counter and sequencing state machine.
// Depends on rat_pkg.
`default_nettype none

module rat_ctrl #(
  parameter int unsigned TableEntries = rat_pkg::TableEntriesDef,
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [rat_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     in_req_type_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  input  wire rat_pkg::dp_status_t      status_i,
  output rat_pkg::ctrl_cmd_t            cmd_o,
  output logic [IdxW-1:0]               rd_addr_o
);

  import rat_pkg::*;

  localparam int unsigned CntW = $clog2(TableEntries + 1);

  // Configuration register
  logic [CfgW-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Entries to scan, capped at the table depth
  logic [31:0] scan_len;

  assign scan_len = (32'(cfg_q) > TableEntries) ? 32'(TableEntries) : 32'(cfg_q);

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            issuing;
  logic            out_free;

  assign issuing  = 32'(cnt_q) < scan_len;
  assign out_free = !out_valid_q || out_ready_i;

  // State, counter and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.res_clear = 1'b1;
          cnt_d           = '0;
          if (in_req_type_i == ReqWrite) begin
            cmd_o.wr_en = 1'b1;
            state_d     = StResult;
          end else begin
            cmd_o.lk_load = 1'b1;
            state_d       = (scan_len == 32'd0) ? StResult : StScan;
          end
        end
      end

      StScan: begin
        if (status_i.match) begin
          // first containing entry wins; later ones in the pipe are dropped
          cmd_o.res_hit = 1'b1;
          cmd_o.flush   = 1'b1;
          state_d       = StResult;
        end else if (issuing) begin
          cmd_o.rd_en = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end else if (!status_i.busy) begin
          state_d = StResult;
        end
      end

      StResult: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign rd_addr_o   = cnt_q[IdxW-1:0];
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // Compare pipe only holds entries during a scan
  a_busy_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.busy |-> state_q == StScan)
    else $error("compare pipe busy outside scan");

  // Scan counter never runs past the entries to scan
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> 32'(cnt_q) <= scan_len)
    else $error("scan counter past entry count");

  // An accepted write answers directly
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_type_i == ReqWrite) |=> state_q == StResult)
    else $error("write not followed by result");

  // Output register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/range_alias_translate_core.sv =====
// Top level of the range alias translation table.
// Depends on rat_pkg, rat_ctrl and rat_datapath.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o, in_word_i): one word is either a
//    table write (req_type 1) or a lookup (req_type 0).
//  - Output channel (out_valid_o/out_ready_i, out_word_o): exactly one word
//    per input word, in order. Writes answer hit 0, address 0.
//  - cfg_we_i/cfg_wdata_i set entries_in_use; write it only while idle.
//  - An accepted write goes straight to the result state, with no scan.
//  - A lookup reads one entry per cycle from the entry RAM into a
//    three-stage compare pipe, scanning entries 0 to N-1 with N =
//    min(entries_in_use, TABLE_ENTRIES); the first hit ends the scan, and
//    an N of 0 answers a miss with no scan. One item is in work at a time:
//    the next word is accepted only once the last result is loaded.
//  - The output register holds a finished word: the next item is accepted
//    while it waits, and that item's result waits for out_ready_i.
//  - Reset clears entries_in_use and every live bit; entry contents are
//    not cleared and need no clearing pass.
`default_nettype none

module range_alias_translate_core #(
  parameter int unsigned TABLE_ENTRIES = rat_pkg::TableEntriesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [rat_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire rat_pkg::req_t            in_word_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output rat_pkg::rsp_t                 out_word_o
);

  import rat_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  ctrl_cmd_t       cmd;
  dp_status_t      status;
  logic [IdxW-1:0] rd_addr;

  rat_ctrl #(
    .TableEntries (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_type_i (in_word_i.req_type),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .rd_addr_o     (rd_addr)
  );

  rat_datapath #(
    .TableEntries (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ===== bench/range_alias_translate_core_tb.sv =====
// Self-checking bench for range_alias_translate_core: a queue-fed driver, a monitor,
// and an in-bench table predictor that is checked word by word.
// Depends on rat_pkg and the range_alias_translate_core RTL.
`timescale 1ns / 1ps

module range_alias_translate_core_tb;

  localparam int unsigned TABLE_N = rat_pkg::TableEntriesDef;

  // DUT connections, all known from time zero
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [rat_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  rat_pkg::req_t            in_word_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  rat_pkg::rsp_t            out_word_o;

  range_alias_translate_core #(
    .TABLE_ENTRIES(TABLE_N)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Word queues and run counters
  rat_pkg::req_t pending_word_q[$];
  rat_pkg::rsp_t expected_alias_q[$];
  int unsigned   words_queued   = 0;
  int unsigned   words_accepted = 0;
  int unsigned   words_checked  = 0;
  int unsigned   lookups_seen   = 0;
  int unsigned   writes_seen    = 0;
  int unsigned   hits_seen      = 0;
  int unsigned   errors         = 0;
  bit            in_idle_en     = 1'b0;
  bit            out_idle_en    = 1'b0;

  // Predictor state: scan count and the alias table
  logic [rat_pkg::CfgW-1:0] scan_count = '0;
  logic                     tbl_live[TABLE_N];
  logic [63:0]              tbl_base[TABLE_N];
  logic [63:0]              tbl_len[TABLE_N];
  logic [63:0]              tbl_alias[TABLE_N];

  // Stimulus-side shadow of the table, advanced as words are generated
  logic                     gen_live[TABLE_N];
  logic [63:0]              gen_base[TABLE_N];
  logic [63:0]              gen_len[TABLE_N];

  initial begin
    for (int i = 0; i < TABLE_N; i++) begin
      tbl_live[i]  = 1'b0;
      tbl_base[i]  = '0;
      tbl_len[i]   = '0;
      tbl_alias[i] = '0;
      gen_live[i]  = 1'b0;
      gen_base[i]  = '0;
      gen_len[i]   = '0;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Expected result of one accepted word; a write also updates the table
  function automatic rat_pkg::rsp_t translate_word(rat_pkg::req_t w);
    rat_pkg::rsp_t r;
    int unsigned   span;
    logic [64:0]   acc_end;
    logic [64:0]   ent_end;
    r = '0;
    if (w.req_type == rat_pkg::ReqWrite) begin
      writes_seen++;
      if (w.entry_index < TABLE_N) begin
        tbl_live[w.entry_index]  = w.entry_live;
        tbl_base[w.entry_index]  = w.entry_base;
        tbl_len[w.entry_index]   = w.entry_length;
        tbl_alias[w.entry_index] = w.entry_alias;
      end
    end else begin
      lookups_seen++;
      span = (scan_count > TABLE_N) ? TABLE_N : scan_count;
      // first live entry that holds the whole access wins; ends kept at 65 bits
      for (int i = 0; i < span; i++) begin
        if (!r.hit && tbl_live[i]) begin
          acc_end = {1'b0, w.lookup_address} + {1'b0, w.access_size};
          ent_end = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
          if (w.lookup_address >= tbl_base[i] && acc_end <= ent_end) begin
            r.hit           = 1'b1;
            r.alias_address = tbl_alias[i] + (w.lookup_address - tbl_base[i]);
          end
        end
      end
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Uniform-ish value in [0, x]
  function automatic logic [63:0] rand_upto(logic [63:0] x);
    if (&x) return rand64();
    return rand64() % (x + 64'd1);
  endfunction

  // Word with every field random; callers overwrite what matters
  function automatic rat_pkg::req_t random_word();
    rat_pkg::req_t w;
    w.req_type       = 1'($urandom());
    w.entry_index    = 4'($urandom());
    w.entry_live     = 1'($urandom());
    w.entry_base     = rand64();
    w.entry_length   = rand64();
    w.entry_alias    = rand64();
    w.lookup_address = rand64();
    w.access_size    = rand64();
    return w;
  endfunction

  task automatic add_write(logic [3:0] idx, logic live, logic [63:0] base,
                           logic [63:0] len, logic [63:0] alias_base);
    rat_pkg::req_t w;
    w              = random_word();
    w.req_type     = rat_pkg::ReqWrite;
    w.entry_index  = idx;
    w.entry_live   = live;
    w.entry_base   = base;
    w.entry_length = len;
    w.entry_alias  = alias_base;
    gen_live[idx]  = live;
    gen_base[idx]  = base;
    gen_len[idx]   = len;
    pending_word_q.push_back(w);
    words_queued++;
  endtask

  task automatic add_lookup(logic [63:0] addr, logic [63:0] size);
    rat_pkg::req_t w;
    w                = random_word();
    w.req_type       = rat_pkg::ReqLookup;
    w.lookup_address = addr;
    w.access_size    = size;
    pending_word_q.push_back(w);
    words_queued++;
  endtask

  // Random table write: small, wide, top-of-space, empty and overlapping ranges
  task automatic add_rand_write();
    logic [3:0]  idx;
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] alias_base;
    int unsigned other;
    idx = 4'($urandom_range(0, TABLE_N - 1));
    case ($urandom_range(0, 5))
      0: begin
        base = rand64();
        len  = 64'($urandom_range(1, 4096));
      end
      1: begin
        base = 64'($urandom());
        len  = 64'($urandom());
      end
      2: begin
        base = ~64'($urandom_range(0, 4095));
        len  = 64'($urandom_range(0, 8192));
      end
      3: begin
        base = rand64();
        len  = '0;
      end
      4: begin
        base = 64'($urandom_range(0, 65535));
        len  = rand64() | 64'h8000_0000_0000_0000;
      end
      default: begin
        other = $urandom_range(0, TABLE_N - 1);
        base  = gen_base[other] + 64'($urandom_range(0, 64));
        len   = 64'($urandom_range(0, 256));
      end
    endcase
    alias_base = ($urandom_range(0, 3) == 0) ? ~64'($urandom_range(0, 255)) : rand64();
    add_write(idx, ($urandom_range(0, 9) != 0), base, len, alias_base);
  endtask

  // Random lookup: mostly aimed inside a live entry, some at its edges, some noise
  task automatic add_rand_lookup();
    int unsigned kind;
    int unsigned j;
    bit          found;
    logic [63:0] b;
    logic [63:0] len;
    logic [63:0] off;
    logic [63:0] sz;
    logic [63:0] rem;
    kind  = $urandom_range(0, 99);
    found = 1'b0;
    j     = $urandom_range(0, TABLE_N - 1);
    for (int k = 0; k < TABLE_N; k++) begin
      if (!found && gen_live[(j + k) % TABLE_N]) begin
        j     = (j + k) % TABLE_N;
        found = 1'b1;
      end
    end
    if (found && kind < 80) begin
      b   = gen_base[j];
      len = gen_len[j];
      if (kind < 60) begin
        case ($urandom_range(0, 4))
          0: begin
            off = '0;
            sz  = len;
          end
          1: begin
            off = rand_upto(len);
            sz  = len - off;
          end
          2: begin
            off = rand_upto(len);
            sz  = '0;
          end
          3: begin
            off = rand_upto(len);
            rem = len - off;
            sz  = ($urandom_range(0, 1) != 0) ? rand_upto(rem) :
                                                 rand_upto((rem > 64) ? 64'd64 : rem);
          end
          default: begin
            off = len;
            sz  = '0;
          end
        endcase
        add_lookup(b + off, sz);
      end else if (kind < 70) begin
        add_lookup(b - 64'd1, 64'($urandom_range(0, 8)));
      end else begin
        // one byte past the entry end
        sz  = rand_upto(len);
        off = len - sz + 64'd1;
        add_lookup(b + off, sz);
      end
    end else begin
      add_lookup((kind % 2 != 0) ? rand64() : 64'($urandom_range(0, 8191)),
                 ($urandom_range(0, 1) != 0) ? rand64() : 64'($urandom_range(0, 16)));
    end
  endtask

  // Block until every queued word is in and answered, then let the pipe settle
  task automatic drain();
    while (words_accepted != words_queued || expected_alias_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_entries(logic [rat_pkg::CfgW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    scan_count   = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Driver: presents the next pending word, holds it until accepted
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_alias_q.push_back(translate_word(in_word_i));
        words_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_word_q.size() != 0) begin
          in_word_i  <= pending_word_q.pop_front();
          in_valid_i <= 1'b1;
          in_gap     <= in_idle_en ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction
  int unsigned out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_alias_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result hit=%0b addr=%h",
                                    out_word_o.hit, out_word_o.alias_address));
        end else begin
          rat_pkg::rsp_t want;
          want = expected_alias_q.pop_front();
          words_checked++;
          if (out_word_o.hit !== want.hit)
            report_mismatch($sformatf("result %0d hit %b, want %b",
                                      words_checked, out_word_o.hit, want.hit));
          if (out_word_o.alias_address !== want.alias_address)
            report_mismatch($sformatf("result %0d alias_address %h, want %h", words_checked,
                                      out_word_o.alias_address, want.alias_address));
          if (want.hit) hits_seen++;
        end
      end
      if (out_gap != 0) begin
        out_gap     <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
        out_gap     <= pick_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TIMEOUT: %0d words queued, %0d accepted, %0d checked",
             words_queued, words_accepted, words_checked);
    $display("Test completed with failures");
    $finish;
  end

  // Sequence: reset, directed words, then random phases at several scan counts
  logic [rat_pkg::CfgW-1:0] phase_count[7] = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd12, 5'd16};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // scan count still 0 after reset: everything misses
    add_write(4'd0, 1'b1, 64'h1000, 64'h100, 64'h8000);
    add_lookup(64'h1000, 64'd4);
    drain();

    set_entries(5'd16);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    add_lookup(64'h1000, 64'd4);
    add_lookup(64'h10FC, 64'd4);            // ends exactly at entry end
    add_lookup(64'h10FD, 64'd4);            // one byte too far
    add_lookup(64'h0FFF, 64'd1);            // just below base
    add_lookup(64'h1100, 64'd0);            // empty access at the end
    // entry ending exactly at the top of the address space
    add_write(4'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'h100, 64'h10);
    add_lookup(64'hFFFF_FFFF_FFFF_FFF0, 64'h10);
    add_lookup(64'hFFFF_FFFF_FFFF_FFF0, 64'h11);
    // whole space, alias sum wraps
    add_write(4'd2, 1'b1, 64'h0, '1, '1);
    add_lookup(64'h5, 64'd1);
    add_lookup('1, 64'd0);
    add_lookup(64'h0, '1);
    add_lookup(64'h1, '1);
    add_write(4'd2, 1'b0, rand64(), rand64(), rand64());  // retired
    add_lookup(64'h5, 64'd1);
    // zero-length entry in the last slot
    add_write(4'd15, 1'b1, 64'h2000, 64'h0, 64'h3000);
    add_lookup(64'h2000, 64'd0);
    add_lookup(64'h2000, 64'd1);
    // overlapping entries: lower index wins
    add_write(4'd3, 1'b1, 64'h1000, 64'h1000, 64'h9000);
    add_lookup(64'h1010, 64'd1);
    add_lookup(64'h1800, 64'd8);
    drain();

    foreach (phase_count[p]) begin
      set_entries(phase_count[p]);
      in_idle_en  = (p % 3 != 1);
      out_idle_en = (p % 3 != 1);
      for (int n = 0; n < 86; n++) begin
        if (n < 6 || $urandom_range(0, 99) < 30) add_rand_write();
        else add_rand_lookup();
      end
      drain();
    end

    repeat (30) @(negedge clk_i);
    if (expected_alias_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_alias_q.size()));

    $display("Checked %0d result words: %0d lookups (%0d hits), %0d table writes,",
             words_checked, lookups_seen, hits_seen, writes_seen);
    $display("over scan counts 0 to 31 with random stalls on both channels.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
